@@ design/assert_macros.svh @@
// Assertion macros shared by the RTL of the three-axis IIR low-pass.
// No dependencies; assertions compile out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked only while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Checked on every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ design/iir3lp_pkg.sv @@
// Package for the three-axis IIR low-pass: widths, register map, coefficient set.
// No dependencies.
`default_nettype none

package iir3lp_pkg;

    localparam int COEF_W    = 32;
    localparam int HIST_W    = 48;
    localparam int HALF_W    = HIST_W / 2;
    localparam int NUM_TAPS  = 3;
    localparam int NUM_AXES  = 3;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_B3 = 3'd3,
        REG_A1 = 3'd4,
        REG_A2 = 3'd5,
        REG_A3 = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] b3;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
        logic signed [COEF_W-1:0] a3;
    } t_coefs;

    localparam t_coefs COEF_RESET = '{
        b0: 32'sd7824,
        b1: 32'sd23472,
        b2: 32'sd23472,
        b3: 32'sd7824,
        a1: -32'sd771590875,
        a2: 32'sd739942335,
        a3: -32'sd236733229
    };

endpackage

`default_nettype wire

@@ design/iir3lp_axis.sv @@
// One axis of the third-order direct-form-I low-pass: history registers and tap math.
// Depends on iir3lp_pkg.
`default_nettype none

module iir3lp_axis #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_FRAC_BITS = 28,
    parameter int HIST_FRAC_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic                                i_primed,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_x,
    input  iir3lp_pkg::t_coefs                  i_coefs,
    output logic signed [SAMPLE_WIDTH-1:0]      o_y
);
    import iir3lp_pkg::*;

    localparam int FF_W  = SAMPLE_WIDTH + COEF_W + 2 + HIST_FRAC_BITS;
    localparam int FB_W  = COEF_W + HIST_W + 2;
    localparam int ACC_W = ((FF_W > FB_W) ? FF_W : FB_W) + 1;

    localparam logic signed [ACC_W-1:0]  ACC_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [HIST_W:0]   Y_HALF   = (HIST_W + 1)'(1) << (HIST_FRAC_BITS - 1);
    localparam logic signed [HIST_W-1:0] HIST_MAX = {1'b0, {(HIST_W - 1){1'b1}}};
    localparam logic signed [HIST_W-1:0] HIST_MIN = {1'b1, {(HIST_W - 1){1'b0}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MAX = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MIN = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

    logic signed [SAMPLE_WIDTH-1:0]       r_xh [NUM_TAPS];
    logic signed [HIST_W-1:0]             r_yh [NUM_TAPS];

    logic signed [COEF_W-1:0]             w_b  [NUM_TAPS];
    logic signed [COEF_W-1:0]             w_a  [NUM_TAPS];
    logic signed [COEF_W+SAMPLE_WIDTH-1:0] w_pb0;
    logic signed [COEF_W+SAMPLE_WIDTH-1:0] w_pb  [NUM_TAPS];
    logic signed [COEF_W+HALF_W-1:0]      w_pah [NUM_TAPS];
    logic signed [COEF_W+HALF_W:0]        w_pal [NUM_TAPS];
    logic signed [ACC_W-1:0]              w_ff;
    logic signed [ACC_W-1:0]              w_fb;
    logic signed [ACC_W-1:0]              w_acc;
    logic signed [ACC_W-1:0]              w_rnd;
    logic signed [ACC_W-1:0]              w_pre;
    logic signed [HIST_W-1:0]             w_ynew;
    logic signed [HIST_W:0]               w_yr;
    logic signed [SAMPLE_WIDTH-1:0]       w_yout;

    always_comb begin
        w_b[0] = i_coefs.b1;
        w_b[1] = i_coefs.b2;
        w_b[2] = i_coefs.b3;
        w_a[0] = i_coefs.a1;
        w_a[1] = i_coefs.a2;
        w_a[2] = i_coefs.a3;

        w_pb0 = i_coefs.b0 * i_x;
        w_ff  = ACC_W'(w_pb0);
        w_fb  = '0;
        for (int t = 0; t < NUM_TAPS; t++) begin
            w_pb[t]  = w_b[t] * r_xh[t];
            // 48-bit history split into two halves to keep each product at most 32 x 25
            w_pah[t] = w_a[t] * $signed(r_yh[t][HIST_W-1:HALF_W]);
            w_pal[t] = w_a[t] * $signed({1'b0, r_yh[t][HALF_W-1:0]});
            w_ff     = w_ff + ACC_W'(w_pb[t]);
            w_fb     = w_fb + (ACC_W'(w_pah[t]) <<< HALF_W) + ACC_W'(w_pal[t]);
        end

        w_acc = (w_ff <<< HIST_FRAC_BITS) - w_fb;
        w_rnd = (w_acc + ACC_HALF) >>> COEF_FRAC_BITS;
        w_pre = i_primed ? w_rnd : (ACC_W'(i_x) <<< HIST_FRAC_BITS);

        if ((&w_pre[ACC_W-1:HIST_W-1]) || !(|w_pre[ACC_W-1:HIST_W-1])) begin
            w_ynew = w_pre[HIST_W-1:0];
        end else begin
            w_ynew = w_pre[ACC_W-1] ? HIST_MIN : HIST_MAX;
        end

        w_yr = ($signed({w_ynew[HIST_W-1], w_ynew}) + Y_HALF) >>> HIST_FRAC_BITS;
        if ((&w_yr[HIST_W:SAMPLE_WIDTH-1]) || !(|w_yr[HIST_W:SAMPLE_WIDTH-1])) begin
            w_yout = w_yr[SAMPLE_WIDTH-1:0];
        end else begin
            w_yout = w_yr[HIST_W] ? OUT_MIN : OUT_MAX;
        end

        o_y = i_primed ? w_yout : i_x;
    end

    // first transaction fills every tap with itself
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xh[0] <= i_x;
            r_yh[0] <= w_ynew;
            for (int t = 1; t < NUM_TAPS; t++) begin
                r_xh[t] <= i_primed ? r_xh[t-1] : i_x;
                r_yh[t] <= i_primed ? r_yh[t-1] : w_ynew;
            end
        end
    end

endmodule

`default_nettype wire

@@ design/three_axis_iir3_lowpass.sv @@
// An input transaction passes the input register and then the result register on its way
// to the result transaction; m_axis_tvalid is set when the input register commits.
// Throughput: one transaction per cycle while m_axis_tready is high; the seven-tap sum
// per axis and the history update close combinationally between the two registers.
// Reset (synchronous, active low): empties both registers, clears the primed flag and
// restores the default coefficient set. The first sample after reset primes all history.
`default_nettype none
`include "assert_macros.svh"

module three_axis_iir3_lowpass #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_FRAC_BITS = 28,
    parameter int HIST_FRAC_BITS = 24
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    // axis_x, axis_y, axis_z, zero pad
    input  logic [((3 * SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    // filtered_x, filtered_y, filtered_z, zero pad
    output logic [((3 * SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,
    input  logic                                        i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  logic [iir3lp_pkg::CFG_IDX_W-1:0]            i_cfg_index,
    input  logic [iir3lp_pkg::COEF_W-1:0]               i_cfg_data
);
    import iir3lp_pkg::*;

    localparam int DATA_W  = NUM_AXES * SAMPLE_WIDTH;
    localparam int TDATA_W = ((DATA_W + 7) / 8) * 8;

    logic                r_in_valid;
    logic [DATA_W-1:0]   r_in_data;
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_out_data;
    logic                r_primed;
    t_coefs              r_coefs;

    logic                w_adv;
    logic                w_commit;
    logic [DATA_W-1:0]   w_result;

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_commit      = r_in_valid && w_adv;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'(r_out_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_primed    <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (w_commit) begin
                r_primed <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_data <= s_axis_tdata[DATA_W-1:0];
        end
        if (w_commit) begin
            r_out_data <= w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs <= COEF_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_reg_idx'(i_cfg_index))
                REG_B0: r_coefs.b0 <= i_cfg_data;
                REG_B1: r_coefs.b1 <= i_cfg_data;
                REG_B2: r_coefs.b2 <= i_cfg_data;
                REG_B3: r_coefs.b3 <= i_cfg_data;
                REG_A1: r_coefs.a1 <= i_cfg_data;
                REG_A2: r_coefs.a2 <= i_cfg_data;
                REG_A3: r_coefs.a3 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
        iir3lp_axis #(
            .SAMPLE_WIDTH   (SAMPLE_WIDTH),
            .COEF_FRAC_BITS (COEF_FRAC_BITS),
            .HIST_FRAC_BITS (HIST_FRAC_BITS)
        ) u_axis (
            .i_clk    (i_clk),
            .i_en     (w_commit),
            .i_primed (r_primed),
            .i_x      ($signed(r_in_data[g*SAMPLE_WIDTH +: SAMPLE_WIDTH])),
            .i_coefs  (r_coefs),
            .o_y      (w_result[g*SAMPLE_WIDTH +: SAMPLE_WIDTH])
        );
    end

    `ASSERT_CLK(a_out_from_in, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_in_valid))
    `ASSERT_CLK(a_stall_holds, i_clk, i_rst_n,
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_in_data)))
    `ASSERT_CLK(a_out_primed, i_clk, i_rst_n, r_out_valid |-> r_primed)
    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (!r_out_valid && !r_in_valid && !r_primed))

endmodule

`default_nettype wire
